[rtl/core/pdf_pkg.sv]
// ----------------------------------------------------------------------------
// pdf_pkg
// Shared constants and types for the decode stage with operand forwarding.
// ----------------------------------------------------------------------------
package pdf_pkg;

  localparam int REG_W    = 4;
  localparam int DATA_W   = 64;
  localparam int SLOT_W   = 3;
  localparam int NUM_SLOTS = 5;

  // register codes
  localparam logic [REG_W-1:0] REG_NONE = 4'd15;
  localparam logic [REG_W-1:0] REG_SP   = 4'd4;

  // transaction kinds
  localparam logic ACT_POST   = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  // instruction codes
  localparam logic [3:0] OP_RRMOVQ = 4'd2;
  localparam logic [3:0] OP_IRMOVQ = 4'd3;
  localparam logic [3:0] OP_RMMOVQ = 4'd4;
  localparam logic [3:0] OP_MRMOVQ = 4'd5;
  localparam logic [3:0] OP_OPQ    = 4'd6;
  localparam logic [3:0] OP_CALL   = 4'd8;
  localparam logic [3:0] OP_RET    = 4'd9;
  localparam logic [3:0] OP_PUSHQ  = 4'd10;
  localparam logic [3:0] OP_POPQ   = 4'd11;

  // decoded result held in the output register
  typedef struct packed {
    logic [REG_W-1:0]  src_a;
    logic [REG_W-1:0]  src_b;
    logic [REG_W-1:0]  dst_e;
    logic [REG_W-1:0]  dst_m;
    logic [DATA_W-1:0] val_a;
    logic [DATA_W-1:0] val_b;
    logic              bubble;
  } result_t;

endpackage

[rtl/core/pdf_in_if.sv]
// ----------------------------------------------------------------------------
// pdf_in_if
// Input channel: forwarding slot posts and instructions to decode.
// ----------------------------------------------------------------------------
interface pdf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [pdf_pkg::SLOT_W-1:0]    slot;
  logic [pdf_pkg::REG_W-1:0]     slot_reg;
  logic [pdf_pkg::DATA_W-1:0]    slot_value;
  logic [3:0]                    instr_code;
  logic [pdf_pkg::REG_W-1:0]     reg_a;
  logic [pdf_pkg::REG_W-1:0]     reg_b;
  logic [pdf_pkg::DATA_W-1:0]    reg_val_a;
  logic [pdf_pkg::DATA_W-1:0]    reg_val_b;
  logic [3:0]                    ex_icode;
  logic [pdf_pkg::REG_W-1:0]     ex_load_dst;

  modport source (
    output valid, action, slot, slot_reg, slot_value, instr_code, reg_a, reg_b,
           reg_val_a, reg_val_b, ex_icode, ex_load_dst,
    input  ready
  );

  modport sink (
    input  valid, action, slot, slot_reg, slot_value, instr_code, reg_a, reg_b,
           reg_val_a, reg_val_b, ex_icode, ex_load_dst,
    output ready
  );
endinterface

[rtl/core/pdf_out_if.sv]
// ----------------------------------------------------------------------------
// pdf_out_if
// Output channel: decoded registers, forwarded operands and bubble flag.
// ----------------------------------------------------------------------------
interface pdf_out_if;
  logic                        valid;
  logic                        ready;
  logic [pdf_pkg::REG_W-1:0]   src_a;
  logic [pdf_pkg::REG_W-1:0]   src_b;
  logic [pdf_pkg::REG_W-1:0]   dst_e;
  logic [pdf_pkg::REG_W-1:0]   dst_m;
  logic [pdf_pkg::DATA_W-1:0]  val_a;
  logic [pdf_pkg::DATA_W-1:0]  val_b;
  logic                        bubble;

  modport source (
    output valid, src_a, src_b, dst_e, dst_m, val_a, val_b, bubble,
    input  ready
  );

  modport sink (
    input  valid, src_a, src_b, dst_e, dst_m, val_a, val_b, bubble,
    output ready
  );
endinterface

[rtl/core/pipeline_decode_forwarding.sv]
// ----------------------------------------------------------------------------
// pipeline_decode_forwarding
// Decode stage of a five-stage pipeline: source/destination selection,
// operand forwarding from five slots and load-use bubble detection.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready input. A post transaction (action = 0) loads one
//            forwarding slot (0 exec dstE, 1 mem dstM, 2 mem dstE, 3 wb dstM,
//            4 wb dstE); slot codes 5..7 are dropped. A decode transaction
//            (action = 1) produces exactly one result; a post produces none.
//   result : valid/ready output carrying src_a, src_b, dst_e, dst_m, val_a,
//            val_b and bubble.
//   Timing: a decode result is registered and appears in the cycle after
//            acceptance. A post is visible to a decode accepted in the following cycle.
//   Throughput: one transaction per cycle unless the result stalls; selection and the slot compares
//            sit between the slot registers and the single result register.
//   Reset: rst (synchronous) clears the result valid flag and sets every slot
//            to no register with a zero value.
//   Stall: while the result is not taken it holds, and item.ready stays low
//            until the result register is free or drains in the same cycle.
// ----------------------------------------------------------------------------
module pipeline_decode_forwarding (
  input  logic        clk,
  input  logic        rst,
  pdf_in_if.sink      item,
  pdf_out_if.source   result
);

  logic [pdf_pkg::REG_W-1:0]  fwd_dst [pdf_pkg::NUM_SLOTS];
  logic [pdf_pkg::DATA_W-1:0] fwd_val [pdf_pkg::NUM_SLOTS];

  logic             out_valid;
  pdf_pkg::result_t out_data;
  pdf_pkg::result_t res_next;

  logic accept;
  logic is_post;
  logic is_decode;
  logic slot_ok;
  logic ex_is_load;

  // handshake
  assign item.ready = !out_valid || result.ready;
  assign accept     = item.valid && item.ready;
  assign is_post    = (item.action == pdf_pkg::ACT_POST);
  assign is_decode  = (item.action == pdf_pkg::ACT_DECODE);
  assign slot_ok    = (item.slot < pdf_pkg::SLOT_W'(pdf_pkg::NUM_SLOTS));

  // forwarding slot registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pdf_pkg::NUM_SLOTS; i++) begin
        fwd_dst[i] <= pdf_pkg::REG_NONE;
        fwd_val[i] <= '0;
      end
    end else if (accept && is_post && slot_ok) begin
      fwd_dst[item.slot] <= item.slot_reg;
      fwd_val[item.slot] <= item.slot_value;
    end
  end

  // register selection by instruction code
  always_comb begin
    res_next = '0;
    case (item.instr_code)
      pdf_pkg::OP_RRMOVQ: begin
        res_next.src_a = item.reg_a;
        res_next.src_b = pdf_pkg::REG_NONE;
        res_next.dst_e = item.reg_b;
        res_next.dst_m = pdf_pkg::REG_NONE;
      end
      pdf_pkg::OP_IRMOVQ: begin
        res_next.src_a = pdf_pkg::REG_NONE;
        res_next.src_b = pdf_pkg::REG_NONE;
        res_next.dst_e = item.reg_b;
        res_next.dst_m = pdf_pkg::REG_NONE;
      end
      pdf_pkg::OP_RMMOVQ: begin
        res_next.src_a = item.reg_a;
        res_next.src_b = item.reg_b;
        res_next.dst_e = pdf_pkg::REG_NONE;
        res_next.dst_m = pdf_pkg::REG_NONE;
      end
      pdf_pkg::OP_MRMOVQ: begin
        res_next.src_a = pdf_pkg::REG_NONE;
        res_next.src_b = item.reg_b;
        res_next.dst_e = pdf_pkg::REG_NONE;
        res_next.dst_m = item.reg_a;
      end
      pdf_pkg::OP_OPQ: begin
        res_next.src_a = item.reg_a;
        res_next.src_b = item.reg_b;
        res_next.dst_e = item.reg_b;
        res_next.dst_m = pdf_pkg::REG_NONE;
      end
      pdf_pkg::OP_CALL: begin
        res_next.src_a = pdf_pkg::REG_NONE;
        res_next.src_b = pdf_pkg::REG_SP;
        res_next.dst_e = pdf_pkg::REG_SP;
        res_next.dst_m = pdf_pkg::REG_NONE;
      end
      pdf_pkg::OP_RET: begin
        res_next.src_a = pdf_pkg::REG_SP;
        res_next.src_b = pdf_pkg::REG_SP;
        res_next.dst_e = pdf_pkg::REG_SP;
        res_next.dst_m = pdf_pkg::REG_NONE;
      end
      pdf_pkg::OP_PUSHQ: begin
        res_next.src_a = item.reg_a;
        res_next.src_b = pdf_pkg::REG_SP;
        res_next.dst_e = pdf_pkg::REG_SP;
        res_next.dst_m = pdf_pkg::REG_NONE;
      end
      pdf_pkg::OP_POPQ: begin
        res_next.src_a = pdf_pkg::REG_SP;
        res_next.src_b = pdf_pkg::REG_SP;
        res_next.dst_e = pdf_pkg::REG_SP;
        res_next.dst_m = item.reg_a;
      end
      default: begin
        res_next.src_a = pdf_pkg::REG_NONE;
        res_next.src_b = pdf_pkg::REG_NONE;
        res_next.dst_e = pdf_pkg::REG_NONE;
        res_next.dst_m = pdf_pkg::REG_NONE;
      end
    endcase

    // operand forwarding: walk from lowest priority so slot 0 wins
    res_next.val_a = item.reg_val_a;
    res_next.val_b = item.reg_val_b;
    for (int i = pdf_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (fwd_dst[i] == res_next.src_a) res_next.val_a = fwd_val[i];
      if (fwd_dst[i] == res_next.src_b) res_next.val_b = fwd_val[i];
    end
    if (res_next.src_a == pdf_pkg::REG_NONE) res_next.val_a = '0;
    if (res_next.src_b == pdf_pkg::REG_NONE) res_next.val_b = '0;

    // load-use hazard against the instruction in execute
    res_next.bubble = ex_is_load &&
                      ((item.ex_load_dst == res_next.src_a) ||
                       (item.ex_load_dst == res_next.src_b));
  end

  assign ex_is_load = (item.ex_icode == pdf_pkg::OP_MRMOVQ) ||
                      (item.ex_icode == pdf_pkg::OP_POPQ);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item.ready) begin
      out_valid <= accept && is_decode;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_decode) begin
      out_data <= res_next;
    end
  end

  assign result.valid  = out_valid;
  assign result.src_a  = out_data.src_a;
  assign result.src_b  = out_data.src_b;
  assign result.dst_e  = out_data.dst_e;
  assign result.dst_m  = out_data.dst_m;
  assign result.val_a  = out_data.val_a;
  assign result.val_b  = out_data.val_b;
  assign result.bubble = out_data.bubble;

endmodule

[rtl/core/pdf_checker.sv]
// ----------------------------------------------------------------------------
// pdf_checker
// Port-level checks for the decode forwarding stage, bound to pipeline_decode_forwarding.
// ----------------------------------------------------------------------------
module pdf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_action,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pdf_pkg::REG_W-1:0]   out_src_a,
  input logic [pdf_pkg::REG_W-1:0]   out_src_b,
  input logic [pdf_pkg::DATA_W-1:0]  out_val_a,
  input logic [pdf_pkg::DATA_W-1:0]  out_val_b,
  input logic                        out_bubble
);

  // stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_val_a) &&
                               $stable(out_val_b) && $stable(out_bubble))
    else $error("result changed while stalled");

  // every decode transaction yields a result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_action == pdf_pkg::ACT_DECODE) |=> out_valid)
    else $error("decode transaction gave no result");

  // a post transaction with the result side drained yields nothing
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_action == pdf_pkg::ACT_POST) &&
    (!out_valid || out_ready) |=> !out_valid)
    else $error("post transaction produced a result");

  // operands with no source register are zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_src_a != pdf_pkg::REG_NONE) || (out_val_a == '0)) &&
                  ((out_src_b != pdf_pkg::REG_NONE) || (out_val_b == '0)))
    else $error("operand without source is not zero");

endmodule

bind pipeline_decode_forwarding pdf_checker u_pdf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (item.valid),
  .in_ready   (item.ready),
  .in_action  (item.action),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_src_a  (result.src_a),
  .out_src_b  (result.src_b),
  .out_val_a  (result.val_a),
  .out_val_b  (result.val_b),
  .out_bubble (result.bubble)
);
